@@ sv/nkf_pkg.sv @@
// Package for the keyword filter: sizes, operation codes, the inter-cell record and helpers.
`default_nettype none
package nkf_pkg;

  localparam int NUM_PATTERNS = 16;
  localparam int PATTERN_LEN  = 32;

  localparam int IDX_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int LEN_W = $clog2(PATTERN_LEN + 1);
  localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;

  localparam logic [PATTERN_LEN-1:0] PROG_ONE = PATTERN_LEN'(1);

  typedef enum logic [1:0] {
    OP_MSG   = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    logic             vld;
    op_t              op;
    logic [7:0]       char_val;
    logic             blank;
    logic [3:0]       slot;
    logic [4:0]       pos;
    logic             last;
    logic             bad;
    logic [IDX_W-1:0] hit;
  } stage_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    fold_lower = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
  endfunction

endpackage
`default_nettype wire

@@ sv/nkf_in_if.sv @@
// Input channel interface: handshake plus one byte-stream transaction.
`default_nettype none
interface nkf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  logic [3:0] pattern_slot;
  logic [4:0] char_position;
  logic       last;

  modport source (output valid, operation, byte_value, pattern_slot, char_position, last,
                  input ready);
  modport sink   (input valid, operation, byte_value, pattern_slot, char_position, last,
                  output ready);
endinterface
`default_nettype wire

@@ sv/nkf_out_if.sv @@
// Result channel interface: handshake plus the per-message verdict.
`default_nettype none
interface nkf_out_if;
  logic       valid;
  logic       ready;
  logic       bad;
  logic [3:0] matched_slot;

  modport source (output valid, bad, matched_slot, input ready);
  modport sink   (input valid, bad, matched_slot, output ready);
endinterface
`default_nettype wire

@@ sv/nkf_cell.sv @@
// One pattern slot: stored pattern, shift-and progress and a pipeline stage to the next slot.
`default_nettype none
module nkf_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic [nkf_pkg::IDX_W-1:0] cell_idx,
  input  wire nkf_pkg::stage_t          stage_i,
  output nkf_pkg::stage_t               stage_o
);

  logic [7:0]                       chars_r   [nkf_pkg::PATTERN_LEN];
  logic [7:0]                       chars_nxt [nkf_pkg::PATTERN_LEN];
  logic [nkf_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic                             valid_r, valid_nxt;
  logic [nkf_pkg::PATTERN_LEN-1:0]  prog_r, prog_nxt;
  logic                             found_r, found_nxt;
  nkf_pkg::stage_t                  stage_r, stage_nxt;
  logic [nkf_pkg::PATTERN_LEN-1:0]  eq;
  logic [nkf_pkg::PATTERN_LEN-1:0]  top;
  logic [nkf_pkg::PATTERN_LEN-1:0]  d;
  logic                             slot_hit;
  logic                             pos_ok;

  always_comb begin
    for (int i = 0; i < nkf_pkg::PATTERN_LEN; i++) begin
      eq[i]  = (chars_r[i] == stage_i.char_val) && (nkf_pkg::LEN_W'(i) < len_r);
      top[i] = (nkf_pkg::LEN_W'(i + 1) == len_r);
    end
    d        = ((prog_r << 1) | nkf_pkg::PROG_ONE) & eq;
    slot_hit = (nkf_pkg::CMP_W'(stage_i.slot) == nkf_pkg::CMP_W'(cell_idx));
    pos_ok   = (int'(stage_i.pos) < nkf_pkg::PATTERN_LEN);
  end

  always_comb begin
    chars_nxt = chars_r;
    len_nxt   = len_r;
    valid_nxt = valid_r;
    prog_nxt  = prog_r;
    found_nxt = found_r;
    stage_nxt = stage_r;
    if (adv) begin
      stage_nxt = stage_i;
      if (stage_i.vld) begin
        unique case (stage_i.op)
          nkf_pkg::OP_MSG: begin
            if (!stage_i.blank && valid_r && (len_r != '0)) begin
              prog_nxt = d;
              if (|(d & top)) begin
                found_nxt = 1'b1;
              end
            end
            if (stage_i.last) begin
              if (!stage_i.bad && found_nxt) begin
                stage_nxt.bad = 1'b1;
                stage_nxt.hit = cell_idx;
              end
              prog_nxt  = '0;
              found_nxt = 1'b0;
            end
          end
          nkf_pkg::OP_WRITE: begin
            if (slot_hit && pos_ok) begin
              for (int i = 0; i < nkf_pkg::PATTERN_LEN; i++) begin
                if (int'(stage_i.pos) == i) begin
                  chars_nxt[i] = stage_i.char_val;
                end
              end
              prog_nxt  = '0;
              found_nxt = 1'b0;
              if (stage_i.last) begin
                len_nxt   = nkf_pkg::LEN_W'({1'b0, stage_i.pos} + 6'd1);
                valid_nxt = 1'b1;
              end
            end
          end
          nkf_pkg::OP_CLEAR: begin
            len_nxt   = '0;
            valid_nxt = 1'b0;
            prog_nxt  = '0;
            found_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    chars_r <= chars_nxt;
    if (!rst_n) begin
      len_r         <= '0;
      valid_r       <= 1'b0;
      prog_r        <= '0;
      found_r       <= 1'b0;
      stage_r.vld   <= 1'b0;
    end else begin
      len_r   <= len_nxt;
      valid_r <= valid_nxt;
      prog_r  <= prog_nxt;
      found_r <= found_nxt;
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule
`default_nettype wire

@@ sv/normalized_multi_keyword_filter.sv @@
// Top level of the keyword filter: input normalisation, the chain of slot cells and the result register.
// The input channel carries message bytes, pattern byte writes and a clear of all slots.
// Message bytes are folded to lower case and whitespace is skipped before matching.
// Every transaction enters a chain of one cell per pattern slot and moves one cell per
// cycle unless the result channel stalls, so a new transaction can be accepted in every
// cycle without a stall. A message byte marked last yields one result transaction on the
// output channel after passing all cells and the result register; other transactions give none.
// The result gives whether any valid pattern occurred and the lowest matching slot.
// Pattern writes and clears take effect in order with the message bytes around them.
// When the receiver stalls with a result waiting, the whole chain holds and the input
// channel is not ready until the result is taken.
// A synchronous active-low reset empties the chain, invalidates every slot and clears
// all match progress; stored pattern bytes are not cleared and need no clearing pass.
`default_nettype none
module normalized_multi_keyword_filter (
  input  wire logic clk,
  input  wire logic rst_n,
  nkf_in_if.sink    in_chan,
  nkf_out_if.source out_chan
);

  nkf_pkg::stage_t chain [nkf_pkg::NUM_PATTERNS + 1];
  nkf_pkg::stage_t head;
  logic            adv;
  logic            out_valid_r, out_valid_nxt;
  logic            out_bad_r, out_bad_nxt;
  logic [3:0]      out_slot_r, out_slot_nxt;
  logic            produce;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  always_comb begin
    head.vld      = in_chan.valid;
    head.op       = nkf_pkg::op_t'(in_chan.operation);
    head.char_val = (in_chan.operation == nkf_pkg::OP_MSG)
                    ? nkf_pkg::fold_lower(in_chan.byte_value) : in_chan.byte_value;
    head.blank    = nkf_pkg::is_blank(in_chan.byte_value);
    head.slot     = in_chan.pattern_slot;
    head.pos      = in_chan.char_position;
    head.last     = in_chan.last;
    head.bad      = 1'b0;
    head.hit      = '0;
  end

  assign chain[0] = head;

  for (genvar g = 0; g < nkf_pkg::NUM_PATTERNS; g++) begin : g_cell
    nkf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (nkf_pkg::IDX_W'(g)),
      .stage_i  (chain[g]),
      .stage_o  (chain[g + 1])
    );
  end

  assign produce = chain[nkf_pkg::NUM_PATTERNS].vld
                   && (chain[nkf_pkg::NUM_PATTERNS].op == nkf_pkg::OP_MSG)
                   && chain[nkf_pkg::NUM_PATTERNS].last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bad_nxt   = out_bad_r;
    out_slot_nxt  = out_slot_r;
    if (adv) begin
      out_valid_nxt = produce;
      if (produce) begin
        out_bad_nxt  = chain[nkf_pkg::NUM_PATTERNS].bad;
        out_slot_nxt = 4'(chain[nkf_pkg::NUM_PATTERNS].hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_bad_r  <= out_bad_nxt;
    out_slot_r <= out_slot_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.bad          = out_bad_r;
  assign out_chan.matched_slot = out_slot_r;

endmodule
`default_nettype wire

@@ sv/nkf_checker.sv @@
// Port-level checker for the keyword filter and its bind to the top level.
`default_nettype none
module nkf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_bad,
  input wire logic [3:0] out_matched_slot
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while result register is empty");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result is stalled");

  a_clean_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad |-> out_matched_slot == 4'd0)
    else $error("matched slot nonzero without a match");

endmodule

bind normalized_multi_keyword_filter nkf_checker u_nkf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_bad          (out_chan.bad),
  .out_matched_slot (out_chan.matched_slot)
);
`default_nettype wire

@@ dv/nkf_checker.sv @@
// Checker for the keyword filter: watches both channels, predicts each verdict and compares it.
module nkf_scoreboard (
  input  logic clk,
  input  logic rst_n,
  nkf_in_if    in_mon,
  nkf_out_if   out_mon,
  output int   mismatch_count,
  output int   verdicts_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       bad;
    logic [3:0] slot;
  } verdict_t;

  logic [7:0]                      pat_mem     [nkf_pkg::NUM_PATTERNS][nkf_pkg::PATTERN_LEN];
  logic [nkf_pkg::LEN_W-1:0]       pat_len     [nkf_pkg::NUM_PATTERNS];
  logic                            slot_live   [nkf_pkg::NUM_PATTERNS];
  logic [nkf_pkg::PATTERN_LEN-1:0] shift_state [nkf_pkg::NUM_PATTERNS];
  logic                            hit_flag    [nkf_pkg::NUM_PATTERNS];
  verdict_t                        verdict_q   [$];
  verdict_t                        want_v;
  verdict_t                        next_v;

  function automatic logic skip_char(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'h20 : c;
  endfunction

  task automatic forget_progress();
    for (int s = 0; s < nkf_pkg::NUM_PATTERNS; s++) begin
      shift_state[s] = '0;
      hit_flag[s]    = 1'b0;
    end
  endtask

  task automatic shift_in(input logic [7:0] c);
    logic [nkf_pkg::PATTERN_LEN-1:0] eq;
    logic [nkf_pkg::PATTERN_LEN-1:0] nxt;
    for (int s = 0; s < nkf_pkg::NUM_PATTERNS; s++) begin
      if (slot_live[s] && (pat_len[s] != '0)) begin
        eq = '0;
        for (int i = 0; i < nkf_pkg::PATTERN_LEN; i++) begin
          if ((i < int'(pat_len[s])) && (pat_mem[s][i] == c)) eq[i] = 1'b1;
        end
        nxt = ((shift_state[s] << 1) | nkf_pkg::PATTERN_LEN'(1)) & eq;
        shift_state[s] = nxt;
        if (nxt[pat_len[s] - 1'b1]) hit_flag[s] = 1'b1;
      end
    end
  endtask

  task automatic apply_transaction();
    case (in_mon.operation)
      nkf_pkg::OP_MSG: begin
        if (!skip_char(in_mon.byte_value)) shift_in(to_lower(in_mon.byte_value));
        if (in_mon.last) begin
          next_v = '0;
          for (int s = nkf_pkg::NUM_PATTERNS - 1; s >= 0; s--) begin
            if (hit_flag[s]) begin
              next_v.bad  = 1'b1;
              next_v.slot = 4'(s);
            end
          end
          verdict_q = {verdict_q, next_v};
          forget_progress();
        end
      end
      nkf_pkg::OP_WRITE: begin
        pat_mem[in_mon.pattern_slot][in_mon.char_position] = in_mon.byte_value;
        shift_state[in_mon.pattern_slot] = '0;
        hit_flag[in_mon.pattern_slot]    = 1'b0;
        if (in_mon.last) begin
          pat_len[in_mon.pattern_slot]   = nkf_pkg::LEN_W'(in_mon.char_position)
                                           + nkf_pkg::LEN_W'(1);
          slot_live[in_mon.pattern_slot] = 1'b1;
        end
      end
      nkf_pkg::OP_CLEAR: begin
        for (int s = 0; s < nkf_pkg::NUM_PATTERNS; s++) begin
          pat_len[s]   = '0;
          slot_live[s] = 1'b0;
        end
        forget_progress();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < nkf_pkg::NUM_PATTERNS; s++) begin
        pat_len[s]   = '0;
        slot_live[s] = 1'b0;
      end
      forget_progress();
      verdict_q.delete();
      mismatch_count = 0;
      verdicts_pending <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result transaction: bad=%0b slot=%0d",
                     out_mon.bad, out_mon.matched_slot);
          end
        end else begin
          want_v = verdict_q.pop_front();
          if ((out_mon.bad !== want_v.bad) || (out_mon.matched_slot !== want_v.slot)) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch: got bad=%0b slot=%0d, expected bad=%0b slot=%0d",
                       out_mon.bad, out_mon.matched_slot, want_v.bad, want_v.slot);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) apply_transaction();
      verdicts_pending <= verdict_q.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the keyword filter: clock, reset, stimulus, result sink, watchdog and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         ITEM_TARGET  = 1750;
  localparam int         CALM_TAIL    = 150;
  localparam int         STALL_LIMIT  = 1000;
  localparam int         DRAIN_CYCLES = 2 * nkf_pkg::NUM_PATTERNS + 8;
  localparam logic [1:0] OP_SPARE     = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches;
  int   pending;
  int   items_sent = 0;
  bit   calm = 1'b0;

  logic [7:0] stored_byte [nkf_pkg::NUM_PATTERNS][nkf_pkg::PATTERN_LEN];
  bit         byte_known  [nkf_pkg::NUM_PATTERNS][nkf_pkg::PATTERN_LEN];
  int         stored_len  [nkf_pkg::NUM_PATTERNS];
  bit         slot_armed  [nkf_pkg::NUM_PATTERNS];

  nkf_in_if  in_chan ();
  nkf_out_if out_chan ();

  normalized_multi_keyword_filter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  nkf_scoreboard u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_chan),
    .out_mon          (out_chan),
    .mismatch_count   (mismatches),
    .verdicts_pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 0) ? 8'h20 : 8'h08 + 8'(k);
  endfunction

  function automatic logic [7:0] filler_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 8'h61 + 8'($urandom_range(0, 3));
    if (r < 15) return 8'h41 + 8'($urandom_range(0, 3));
    if (r < 17) return blank_char();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] keyword_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'h61 + 8'($urandom_range(0, 3));
    if (r < 92) return 8'h41 + 8'($urandom_range(0, 3));
    return 8'($urandom);
  endfunction

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
  endtask

  task automatic send(input logic [1:0] op, input logic [7:0] b, input logic [3:0] slot,
                      input logic [4:0] pos, input logic last);
    if (!calm && ($urandom_range(0, 6) == 0)) hold_off($urandom_range(1, 4));
    @(negedge clk);
    in_chan.valid         <= 1'b1;
    in_chan.operation     <= op;
    in_chan.byte_value    <= b;
    in_chan.pattern_slot  <= slot;
    in_chan.char_position <= pos;
    in_chan.last          <= last;
    do @(posedge clk); while (!in_chan.ready);
    if (op != OP_SPARE) items_sent++;
    if (op == nkf_pkg::OP_WRITE) begin
      stored_byte[slot][pos] = b;
      byte_known[slot][pos]  = 1'b1;
      if (last) begin
        stored_len[slot] = int'(pos) + 1;
        slot_armed[slot] = 1'b1;
      end
    end else if (op == nkf_pkg::OP_CLEAR) begin
      for (int s = 0; s < nkf_pkg::NUM_PATTERNS; s++) begin
        stored_len[s] = 0;
        slot_armed[s] = 1'b0;
      end
    end
  endtask

  task automatic wait_for_verdicts();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_keyword(input logic [3:0] slot, input int len);
    for (int p = 0; p < len; p++) begin
      send(nkf_pkg::OP_WRITE, keyword_char(), slot, 5'(p), p == len - 1);
    end
  endtask

  task automatic send_stray_write();
    logic [3:0] slot;
    logic [4:0] pos;
    logic       last;
    slot = 4'($urandom);
    pos  = 5'($urandom);
    last = 1'($urandom);
    for (int p = 0; p < int'(pos); p++) begin
      if (!byte_known[slot][p]) last = 1'b0;
    end
    send(nkf_pkg::OP_WRITE, 8'($urandom), slot, pos, last);
  endtask

  task automatic send_message();
    logic [7:0] text [$];
    logic [7:0] c;
    int         pick;
    int         n;
    int         parts;
    parts = $urandom_range(1, 4);
    for (int k = 0; k < parts; k++) begin
      pick = -1;
      if ($urandom_range(0, 2) != 0) begin
        for (int t = 0; t < 8; t++) begin
          n = $urandom_range(0, nkf_pkg::NUM_PATTERNS - 1);
          if (slot_armed[n] && (pick < 0)) pick = n;
        end
      end
      if (pick >= 0) begin
        for (int p = 0; p < stored_len[pick]; p++) begin
          c = stored_byte[pick][p];
          if ((c >= 8'h61) && (c <= 8'h7A) && ($urandom_range(0, 1) != 0)) c = c - 8'h20;
          if ($urandom_range(0, 19) != 0) text = {text, c};
          if ($urandom_range(0, 5) == 0) text = {text, blank_char()};
        end
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) text = {text, filler_char()};
      end
    end
    if (text.size() == 0) text = {text, filler_char()};
    foreach (text[i]) begin
      send(nkf_pkg::OP_MSG, text[i], 4'($urandom), 5'($urandom), i == text.size() - 1);
    end
  endtask

  initial begin : result_sink
    int hold;
    bit steady;
    hold = 0;
    steady = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) steady = !steady;
      if (calm || steady) begin
        out_chan.ready <= 1'b1;
      end else if (hold > 0) begin
        out_chan.ready <= 1'b0;
        hold--;
      end else if ($urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int r;
    in_chan.valid         = 1'b0;
    in_chan.operation     = nkf_pkg::OP_MSG;
    in_chan.byte_value    = 8'h00;
    in_chan.pattern_slot  = 4'h0;
    in_chan.char_position = 5'd0;
    in_chan.last          = 1'b0;
    for (int s = 0; s < nkf_pkg::NUM_PATTERNS; s++) begin
      stored_len[s] = 0;
      slot_armed[s] = 1'b0;
      for (int p = 0; p < nkf_pkg::PATTERN_LEN; p++) byte_known[s][p] = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(nkf_pkg::OP_MSG,   8'h00, 4'd0,  5'd0,  1'b1);
    send(nkf_pkg::OP_WRITE, "a",   4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_WRITE, "b",   4'd0,  5'd1,  1'b1);
    send(nkf_pkg::OP_WRITE, 8'hFF, 4'd15, 5'd0,  1'b1);
    send(nkf_pkg::OP_WRITE, 8'h00, 4'd15, 5'd31, 1'b0);
    send(nkf_pkg::OP_MSG,   "A",   4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_MSG,   8'h20, 4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_MSG,   "B",   4'd0,  5'd0,  1'b1);
    send(nkf_pkg::OP_MSG,   8'hFF, 4'd15, 5'd31, 1'b1);
    send(OP_SPARE,          8'hFF, 4'd15, 5'd31, 1'b1);
    send(nkf_pkg::OP_MSG,   "a",   4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_MSG,   "b",   4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_MSG,   8'h09, 4'd0,  5'd0,  1'b1);
    send(nkf_pkg::OP_MSG,   "a",   4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_WRITE, "a",   4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_MSG,   "b",   4'd0,  5'd0,  1'b1);
    send(nkf_pkg::OP_MSG,   "a",   4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_MSG,   8'h0D, 4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_MSG,   "b",   4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_MSG,   8'hFF, 4'd0,  5'd0,  1'b1);
    send(nkf_pkg::OP_CLEAR, 8'hFF, 4'd15, 5'd31, 1'b1);
    send(nkf_pkg::OP_MSG,   "a",   4'd0,  5'd0,  1'b0);
    send(nkf_pkg::OP_MSG,   "b",   4'd0,  5'd0,  1'b1);
    send(nkf_pkg::OP_WRITE, "Z",   4'd7,  5'd0,  1'b1);
    send(nkf_pkg::OP_MSG,   "Z",   4'd0,  5'd0,  1'b1);
    wait_for_verdicts();

    while (items_sent < ITEM_TARGET) begin
      calm = (items_sent >= ITEM_TARGET - CALM_TAIL);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_message();
      end else if (r < 68) begin
        r = $urandom_range(0, 99);
        if (r < 80) load_keyword(4'($urandom), $urandom_range(1, 5));
        else if (r < 95) load_keyword(4'($urandom), $urandom_range(6, 12));
        else load_keyword(4'($urandom), nkf_pkg::PATTERN_LEN);
      end else if (r < 72) begin
        send(nkf_pkg::OP_CLEAR, 8'($urandom), 4'($urandom), 5'($urandom), 1'($urandom));
      end else if (r < 84) begin
        send_stray_write();
      end else if (r < 90) begin
        send(OP_SPARE, 8'($urandom), 4'($urandom), 5'($urandom), 1'($urandom));
      end else if ((r < 93) && !calm) begin
        wait_for_verdicts();
      end else begin
        send_message();
      end
    end

    wait_for_verdicts();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if ((mismatches == 0) && (pending == 0)) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
